@@ rtl/mme_pkg.sv @@
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Shared constants, request and register codes, sequencer states and the
// control word that travels from the sequencer to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mme_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_DIM_DEF    = 8;
	localparam int ELEM_WIDTH_DEF = 16;

	// Fixed field widths of the ports.
	localparam int OUT_W  = 40;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 4;
	localparam int REQ_W  = 2;
	localparam int CIDX_W = 2;
	localparam int IN_W   = 16;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_LEFT    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RIGHT   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_LEFT_ROWS  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_INNER_SIZE = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_RIGHT_COLS = 2'd2;

	// Reset value of every size register.
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT
	} seq_state_t;

	// One multiply-accumulate step issued by the sequencer.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctrl_t;

endpackage

@@ rtl/mme_store.sv @@
// ----------------------------------------------------------------------------
// Matrix element store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module mme_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/mme_mac.sv @@
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Multiplies one left and one right element per cycle, registers the product
// and adds it into a 40-bit accumulator that saturates after each addition.
// ----------------------------------------------------------------------------
module mme_mac #(
	parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mme_pkg::mac_ctrl_t                ctrl,
	input  logic signed [ELEM_WIDTH-1:0]      a_data,
	input  logic signed [ELEM_WIDTH-1:0]      b_data,
	input  logic                              consume,
	output logic signed [mme_pkg::OUT_W-1:0]  acc_value,
	output logic                              done
);

	localparam int PW = 2 * ELEM_WIDTH;
	localparam int SW = ((mme_pkg::OUT_W > PW) ? mme_pkg::OUT_W : PW) + 1;
	localparam logic signed [SW-1:0] HI_V =
		$signed(SW'({1'b0, {(mme_pkg::OUT_W-1){1'b1}}}));
	localparam logic signed [SW-1:0] LO_V = -HI_V - SW'(1);

	mme_pkg::mac_ctrl_t               ctrl_s1;
	mme_pkg::mac_ctrl_t               ctrl_s2;
	logic signed [PW-1:0]             prod_s2;
	logic signed [mme_pkg::OUT_W-1:0] acc_q;
	logic                             done_q;
	logic signed [SW-1:0]             base;
	logic signed [SW-1:0]             sum;
	logic signed [mme_pkg::OUT_W-1:0] sum_sat;

	// Control tags follow the read stage and the multiply stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
		end
	end

	// Product register.
	always_ff @(posedge clk) begin
		prod_s2 <= a_data * b_data;
	end

	// Saturating addition of the product into the running sum.
	always_comb begin
		base = ctrl_s2.first ? '0 : SW'(acc_q);
		sum  = base + SW'(prod_s2);
		if (sum > HI_V) begin
			sum_sat = mme_pkg::OUT_W'(HI_V);
		end else if (sum < LO_V) begin
			sum_sat = mme_pkg::OUT_W'(LO_V);
		end else begin
			sum_sat = mme_pkg::OUT_W'(sum);
		end
	end

	// Accumulator.
	always_ff @(posedge clk) begin
		if (ctrl_s2.valid) begin
			acc_q <= sum_sat;
		end
	end

	// Done flag: set after the last step of a dot product, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (ctrl_s2.valid && ctrl_s2.last) begin
			done_q <= 1'b1;
		end else if (consume) begin
			done_q <= 1'b0;
		end
	end

	assign acc_value = acc_q;
	assign done      = done_q;

endmodule

@@ rtl/mme_seq.sv @@
// ----------------------------------------------------------------------------
// Product sequencer
// Walks the output entries in row-major order and, for each, issues one
// multiply-accumulate step per inner index, then hands the sum to the output.
// ----------------------------------------------------------------------------
module mme_seq #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF,
	parameter int AW      = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [mme_pkg::REQ_W-1:0]    req_type,
	input  logic [mme_pkg::CFG_W-1:0]    left_rows,
	input  logic [mme_pkg::CFG_W-1:0]    inner_size,
	input  logic [mme_pkg::CFG_W-1:0]    right_cols,
	input  logic                         acc_done,
	input  logic                         out_free,
	output logic                         in_ready,
	output mme_pkg::mac_ctrl_t           ctrl,
	output logic [AW-1:0]                rd_addr_l,
	output logic [AW-1:0]                rd_addr_r,
	output logic                         load,
	output logic [mme_pkg::IDX_W-1:0]    ent_row,
	output logic [mme_pkg::IDX_W-1:0]    ent_col,
	output logic                         ent_last
);

	localparam int CW = $clog2(MAX_DIM + 1);

	mme_pkg::seq_state_t state_q;
	mme_pkg::seq_state_t state_d;
	logic [CW-1:0]       i_q;
	logic [CW-1:0]       j_q;
	logic [CW-1:0]       z_q;
	logic [CW-1:0]       nr_q;
	logic [CW-1:0]       nk_q;
	logic [CW-1:0]       nc_q;
	logic                start;
	logic                z_last;
	logic                j_last;

	// A size register of zero counts as one; larger than the store saturates.
	function automatic logic [CW-1:0] eff_size(input logic [mme_pkg::CFG_W-1:0] v);
		if (v == '0) begin
			return CW'(1);
		end else if (32'(v) > MAX_DIM) begin
			return CW'(MAX_DIM);
		end else begin
			return CW'(v);
		end
	endfunction

	assign start  = (state_q == mme_pkg::S_IDLE) && in_valid
		&& (req_type == mme_pkg::REQ_COMPUTE);
	assign z_last = (z_q == nk_q - CW'(1));
	assign j_last = (j_q == nc_q - CW'(1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mme_pkg::S_IDLE: begin
				if (start) begin
					state_d = mme_pkg::S_ISSUE;
				end
			end
			mme_pkg::S_ISSUE: begin
				if (z_last) begin
					state_d = mme_pkg::S_WAIT;
				end
			end
			mme_pkg::S_WAIT: begin
				if (load) begin
					state_d = ent_last ? mme_pkg::S_IDLE : mme_pkg::S_ISSUE;
				end
			end
			default: begin
				state_d = mme_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready = 1'b0;
		ctrl     = '0;
		load     = 1'b0;
		case (state_q)
			mme_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			mme_pkg::S_ISSUE: begin
				ctrl.valid = 1'b1;
				ctrl.first = (z_q == '0);
				ctrl.last  = z_last;
			end
			mme_pkg::S_WAIT: begin
				load = acc_done && out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Entry and inner counters, and the sizes latched for this transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q  <= '0;
			j_q  <= '0;
			z_q  <= '0;
			nr_q <= CW'(1);
			nk_q <= CW'(1);
			nc_q <= CW'(1);
		end else if (start) begin
			i_q  <= '0;
			j_q  <= '0;
			z_q  <= '0;
			nr_q <= eff_size(left_rows);
			nk_q <= eff_size(inner_size);
			nc_q <= eff_size(right_cols);
		end else if ((state_q == mme_pkg::S_ISSUE) && !z_last) begin
			z_q <= z_q + CW'(1);
		end else if (load) begin
			z_q <= '0;
			if (j_last) begin
				j_q <= '0;
				i_q <= i_q + CW'(1);
			end else begin
				j_q <= j_q + CW'(1);
			end
		end
	end

	// Store addresses: left row i column z, right row z column j.
	assign rd_addr_l = AW'(AW'(i_q) * AW'(MAX_DIM) + AW'(z_q));
	assign rd_addr_r = AW'(AW'(z_q) * AW'(MAX_DIM) + AW'(j_q));

	assign ent_row  = mme_pkg::IDX_W'(i_q);
	assign ent_col  = mme_pkg::IDX_W'(j_q);
	assign ent_last = (i_q == nr_q - CW'(1)) && j_last;

endmodule

@@ rtl/matrix_multiply_engine_unit.sv @@
// Loads: a load transaction is written into its store in the cycle it is accepted.
// A compute transaction runs through every product entry, one after another.
// Each product entry costs one shared multiplier step per inner index plus read,
// multiply and accumulate stages; the input is not ready until the last entry is in the output register.
// Throughput: one load per cycle while idle; each entry finishes before the next is issued.
// Reset: clears control state and sets all three size registers to 8; stores are not cleared.
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Loads two element stores and streams out their signed fixed-point product,
// one entry per result in row-major order, flagging the final entry.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit #(
	parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mme_pkg::REQ_W-1:0]         req_type,
	input  logic [mme_pkg::IDX_W-1:0]         row_index,
	input  logic [mme_pkg::IDX_W-1:0]         col_index,
	input  logic signed [mme_pkg::IN_W-1:0]   entry_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mme_pkg::OUT_W-1:0]  product_value,
	output logic [mme_pkg::IDX_W-1:0]         out_row,
	output logic [mme_pkg::IDX_W-1:0]         out_col,
	output logic                              last_entry,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mme_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]         cfg_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	logic [mme_pkg::CFG_W-1:0]        left_rows_q;
	logic [mme_pkg::CFG_W-1:0]        inner_size_q;
	logic [mme_pkg::CFG_W-1:0]        right_cols_q;
	logic                             in_acc;
	logic                             in_range;
	logic                             we_l;
	logic                             we_r;
	logic [AW-1:0]                    waddr;
	logic signed [ELEM_WIDTH-1:0]     elem;
	logic [AW-1:0]                    rd_addr_l;
	logic [AW-1:0]                    rd_addr_r;
	logic signed [ELEM_WIDTH-1:0]     rdata_l;
	logic signed [ELEM_WIDTH-1:0]     rdata_r;
	mme_pkg::mac_ctrl_t               ctrl;
	logic signed [mme_pkg::OUT_W-1:0] acc_value;
	logic                             acc_done;
	logic                             out_free;
	logic                             load;
	logic [mme_pkg::IDX_W-1:0]        ent_row;
	logic [mme_pkg::IDX_W-1:0]        ent_col;
	logic                             ent_last;
	logic                             out_valid_q;
	logic signed [mme_pkg::OUT_W-1:0] product_q;
	logic [mme_pkg::IDX_W-1:0]        row_q;
	logic [mme_pkg::IDX_W-1:0]        col_q;
	logic                             last_q;

	// Configuration registers; an unknown index is ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rows_q  <= mme_pkg::CFG_RESET;
			inner_size_q <= mme_pkg::CFG_RESET;
			right_cols_q <= mme_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mme_pkg::CFG_LEFT_ROWS:  left_rows_q  <= cfg_data;
				mme_pkg::CFG_INNER_SIZE: inner_size_q <= cfg_data;
				mme_pkg::CFG_RIGHT_COLS: right_cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Store writes; entries outside the store are dropped.
	assign in_acc   = in_valid && in_ready;
	assign in_range = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
	assign we_l     = in_acc && in_range && (req_type == mme_pkg::REQ_LEFT);
	assign we_r     = in_acc && in_range && (req_type == mme_pkg::REQ_RIGHT);
	assign waddr    = AW'(AW'(row_index) * AW'(MAX_DIM) + AW'(col_index));
	assign elem     = ELEM_WIDTH'(entry_value);

	mme_store #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.WIDTH(ELEM_WIDTH)
	) u_left_store (
		.clk  (clk),
		.we   (we_l),
		.waddr(waddr),
		.wdata(elem),
		.raddr(rd_addr_l),
		.rdata(rdata_l)
	);

	mme_store #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.WIDTH(ELEM_WIDTH)
	) u_right_store (
		.clk  (clk),
		.we   (we_r),
		.waddr(waddr),
		.wdata(elem),
		.raddr(rd_addr_r),
		.rdata(rdata_r)
	);

	mme_seq #(
		.MAX_DIM(MAX_DIM),
		.AW     (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.left_rows (left_rows_q),
		.inner_size(inner_size_q),
		.right_cols(right_cols_q),
		.acc_done  (acc_done),
		.out_free  (out_free),
		.in_ready  (in_ready),
		.ctrl      (ctrl),
		.rd_addr_l (rd_addr_l),
		.rd_addr_r (rd_addr_r),
		.load      (load),
		.ent_row   (ent_row),
		.ent_col   (ent_col),
		.ent_last  (ent_last)
	);

	mme_mac #(
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.a_data   (rdata_l),
		.b_data   (rdata_r),
		.consume  (load),
		.acc_value(acc_value),
		.done     (acc_done)
	);

	// Output register: takes a finished entry when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			product_q <= acc_value;
			row_q     <= ent_row;
			col_q     <= ent_col;
			last_q    <= ent_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign product_value = product_q;
	assign out_row       = row_q;
	assign out_col       = col_q;
	assign last_entry    = last_q;

`ifndef SYNTHESIS
	// A compute transaction holds off the input for at least the next cycle.
	a_compute_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_type == mme_pkg::REQ_COMPUTE) |=> !in_ready)
		else $error("input ready right after a compute transaction");

	// A finished entry is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// Stores are only written while no product is in progress.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(we_l || we_r) |-> (in_ready && !ctrl.valid))
		else $error("store written during a product");

	// Loading an entry always consumes a completed dot product.
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> acc_done)
		else $error("entry loaded before its sum was complete");
`endif

endmodule
